[rtl/core/dlb_pkg.sv]
// shared types and constants of the directional label boundary block
package dlb_pkg;

   // field and port widths fixed by the interface
   localparam int unsigned PIXEL_BITS     = 16;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 9;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIDE         = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_THICKNESS    = 2'd3;

   // register reset values
   localparam logic [8:0] FRAME_WIDTH_RESET  = 9'd256;
   localparam logic [8:0] FRAME_HEIGHT_RESET = 9'd256;
   localparam logic [7:0] THICKNESS_RESET    = 8'd1;

   // transaction opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   // probed direction
   typedef enum logic [1:0] {
      SIDE_TOP    = 2'd0,
      SIDE_BOTTOM = 2'd1,
      SIDE_RIGHT  = 2'd2,
      SIDE_LEFT   = 2'd3
   } side_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [8:0] frame_width;
      logic [8:0] frame_height;
      side_type   side;
      logic [7:0] thickness;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;      // latch the accepted transaction
      logic wrap;         // range check positions, store a load
      logic div_step;     // one step of the row/column division
      logic read_center;  // read the label of the emitted pixel
      logic center;       // take the center label, set up the probe
      logic probe;        // bounds check and read of the next neighbor
      logic compare;      // compare the neighbor with the center
      logic deliver;      // hand the result over, advance emit position
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_emit;
      logic pos_in_range;
      logic div_last;
      logic center_zero;
      logic probe_out;
      logic probe_diff;
      logic probe_last;
   } status_type;

endpackage

[rtl/core/directional_label_boundary.sv]
// directional label boundary: top level with registers, result stage, checks
// load transaction: stores the label and returns to idle through sync and wrap, no result
// emit transaction: skips the probe for background or zero thickness, else reads one
// neighbor at a time until one differs, lies outside the frame or thickness is reached
// a stalled waiting result holds the emit; a width change adds a division to the next emit
// synchronous reset: registers to defaults, positions to zero, frame store not cleared
module directional_label_boundary #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256,
   parameter int unsigned LABEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [dlb_pkg::PIXEL_BITS-1:0]       req_pixel_label,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dlb_pkg::PIXEL_BITS-1:0]       rsp_boundary_label,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_write,
   input  logic [dlb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dlb_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   logic [8:0]                    frame_width_ff, frame_height_ff;
   logic [1:0]                    side_ff;
   logic [7:0]                    thickness_ff;
   dlb_pkg::cfg_type              cfg;
   dlb_pkg::cmd_type              dp_cmd;
   dlb_pkg::status_type           dp_status;
   logic                          ctrl_idle, start, out_free, width_written;
   logic [dlb_pkg::PIXEL_BITS-1:0] result_label, rsp_label_ff;
   logic                          frame_end, rsp_valid_ff, rsp_end_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= dlb_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= dlb_pkg::FRAME_HEIGHT_RESET;
         side_ff         <= dlb_pkg::SIDE_TOP;
         thickness_ff    <= dlb_pkg::THICKNESS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dlb_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            dlb_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
            dlb_pkg::REG_SIDE:         side_ff         <= csr_data[1:0];
            dlb_pkg::REG_THICKNESS:    thickness_ff    <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;
   assign cfg.side         = dlb_pkg::side_type'(side_ff);
   assign cfg.thickness    = thickness_ff;

   assign width_written = csr_write && (csr_index == dlb_pkg::REG_FRAME_WIDTH);

   // input handshake
   assign req_stall = !ctrl_idle;
   assign start     = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // controller
   dlb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .width_written (width_written),
      .out_free      (out_free),
      .status        (dp_status),
      .cmd           (dp_cmd),
      .idle          (ctrl_idle)
   );

   // datapath
   dlb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .LABEL_BITS (LABEL_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (dp_cmd),
      .req_opcode      (req_opcode),
      .req_pixel_label (req_pixel_label),
      .status          (dp_status),
      .result_label    (result_label),
      .frame_end       (frame_end)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.deliver) begin
         rsp_label_ff <= result_label;
         rsp_end_ff   <= frame_end;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_boundary_label = rsp_label_ff;
   assign rsp_frame_end      = rsp_end_ff;

   // the block is busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after a transaction");

   // a result is only handed over into a free result register
   a_deliver_into_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.deliver |-> (!rsp_valid || !rsp_stall))
      else $error("result overwrote a waiting transaction");

   // every new result comes from a delivery by the controller
   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dp_cmd.deliver))
      else $error("result appeared without delivery");

endmodule

[rtl/core/dlb_ctrl.sv]
// sequencing state machine of the directional label boundary block
module dlb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                width_written,
   input  logic                out_free,
   input  dlb_pkg::status_type status,
   output dlb_pkg::cmd_type    cmd,
   output logic                idle
);

   typedef enum logic [8:0] {
      ST_IDLE        = 9'b000000001,
      ST_SYNC        = 9'b000000010,
      ST_WRAP        = 9'b000000100,
      ST_DIVIDE      = 9'b000001000,
      ST_READ_CENTER = 9'b000010000,
      ST_CENTER      = 9'b000100000,
      ST_PROBE       = 9'b001000000,
      ST_COMPARE     = 9'b010000000,
      ST_FINISH      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      dirty_ff, dirty_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      dirty_in = dirty_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SYNC;
            end
         end
         ST_SYNC: begin
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            if (!status.is_emit) begin
               state_in = ST_IDLE;
            end else begin
               // row and column are rebuilt once after a width change
               dirty_in = 1'b0;
               if (dirty_ff && status.pos_in_range) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_READ_CENTER;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_READ_CENTER;
            end
         end
         ST_READ_CENTER: begin
            cmd.read_center = 1'b1;
            state_in        = ST_CENTER;
         end
         ST_CENTER: begin
            cmd.center = 1'b1;
            if (status.center_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
            if (status.probe_out) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            if (status.probe_diff || status.probe_last) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (width_written) begin
         dirty_in = 1'b1;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dirty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

[rtl/core/dlb_datapath.sv]
// frame store, positions, divider and neighbor probe of the boundary block
module dlb_datapath #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256,
   parameter int unsigned LABEL_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dlb_pkg::cfg_type                  cfg,
   input  dlb_pkg::cmd_type                  cmd,
   input  logic                              req_opcode,
   input  logic [dlb_pkg::PIXEL_BITS-1:0]    req_pixel_label,
   output dlb_pkg::status_type               status,
   output logic [dlb_pkg::PIXEL_BITS-1:0]    result_label,
   output logic                              frame_end
);

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned SB    = $clog2(DEPTH + 1);
   localparam int unsigned WVB   = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HVB   = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned PW    = WVB + HVB;
   localparam int unsigned DVW   = WVB + RB;
   localparam int unsigned DCB   = $clog2(RB + 1);
   localparam int unsigned KM    = (WVB > HVB) ? WVB : HVB;
   localparam int unsigned KW    = ((KM > 8) ? KM : 8) + 1;

   // clamped geometry and frame size
   logic [WVB-1:0] w_cl;
   logic [HVB-1:0] h_cl;
   logic [PW-1:0]  size_prod;
   logic [SB-1:0]  size_ff;

   // item and positions
   logic                  op_ff;
   logic [LABEL_BITS-1:0] label_ff;
   logic [AB-1:0]         load_pos_ff, load_pos_in;
   logic [AB-1:0]         emit_pos_ff, emit_pos_in;
   logic [RB-1:0]         row_ff, row_in;
   logic [CB-1:0]         col_ff, col_in;
   logic                  load_in_range, emit_in_range, emit_last;
   logic [AB-1:0]         load_addr;

   // divider
   logic [DVW-1:0] rem_ff, rem_nx, dvs_ff;
   logic [RB-1:0]  q_ff, q_nx;
   logic [DCB-1:0] dcnt_ff;
   logic           div_ge;

   // probe
   logic [LABEL_BITS-1:0] store_mem [DEPTH];
   logic [LABEL_BITS-1:0] rd_data_ff, center_ff, result_ff;
   logic [AB-1:0]         probe_ff, probe_next, delta, rd_addr;
   logic [7:0]            k_ff;
   logic                  probe_out, mem_we, mem_re;

   // size clamp, the block treats zero as one and caps at the maximum
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_cl = WVB'(1);
      end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
         w_cl = WVB'(MAX_WIDTH);
      end else begin
         w_cl = WVB'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         h_cl = HVB'(1);
      end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
         h_cl = HVB'(MAX_HEIGHT);
      end else begin
         h_cl = HVB'(cfg.frame_height);
      end
   end

   assign size_prod = PW'(w_cl) * PW'(h_cl);

   // position range checks
   assign load_in_range = SB'(load_pos_ff) < size_ff;
   assign emit_in_range = SB'(emit_pos_ff) < size_ff;
   assign emit_last     = (SB'(emit_pos_ff) + SB'(1)) == size_ff;
   assign load_addr     = load_in_range ? load_pos_ff : '0;

   // restoring division step
   assign div_ge = rem_ff >= dvs_ff;
   assign rem_nx = div_ge ? (rem_ff - dvs_ff) : rem_ff;
   assign q_nx   = RB'({q_ff, div_ge});

   // neighbor address step and frame edge test
   always_comb begin
      delta     = AB'(1);
      probe_out = 1'b0;
      case (cfg.side)
         dlb_pkg::SIDE_TOP: begin
            delta     = AB'(w_cl);
            probe_out = KW'(k_ff) > KW'(row_ff);
         end
         dlb_pkg::SIDE_BOTTOM: begin
            delta     = AB'(w_cl);
            probe_out = (KW'(row_ff) + KW'(k_ff)) >= KW'(h_cl);
         end
         dlb_pkg::SIDE_RIGHT: begin
            probe_out = (KW'(col_ff) + KW'(k_ff)) >= KW'(w_cl);
         end
         default: begin
            probe_out = KW'(k_ff) > KW'(col_ff);
         end
      endcase
      if ((cfg.side == dlb_pkg::SIDE_TOP) || (cfg.side == dlb_pkg::SIDE_LEFT)) begin
         probe_next = probe_ff - delta;
      end else begin
         probe_next = probe_ff + delta;
      end
   end

   // frame store port control
   assign mem_we  = cmd.wrap && (op_ff == dlb_pkg::OP_LOAD);
   assign mem_re  = cmd.read_center || cmd.probe;
   assign rd_addr = cmd.read_center ? emit_pos_ff : probe_next;

   // frame store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[load_addr] <= label_ff;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // next positions
   always_comb begin
      load_pos_in = load_pos_ff;
      emit_pos_in = emit_pos_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      if (mem_we) begin
         if ((SB'(load_addr) + SB'(1)) >= size_ff) begin
            load_pos_in = '0;
         end else begin
            load_pos_in = load_addr + AB'(1);
         end
      end
      if (cmd.wrap && (op_ff == dlb_pkg::OP_EMIT) && !emit_in_range) begin
         emit_pos_in = '0;
         row_in      = '0;
         col_in      = '0;
      end
      if (cmd.div_step && status.div_last) begin
         row_in = q_nx;
         col_in = CB'(rem_nx);
      end
      if (cmd.deliver) begin
         if (emit_last) begin
            emit_pos_in = '0;
            row_in      = '0;
            col_in      = '0;
         end else begin
            emit_pos_in = emit_pos_ff + AB'(1);
            if ((KW'(col_ff) + KW'(1)) == KW'(w_cl)) begin
               col_in = '0;
               row_in = row_ff + RB'(1);
            end else begin
               col_in = col_ff + CB'(1);
            end
         end
      end
   end

   // position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         emit_pos_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         load_pos_ff <= load_pos_in;
         emit_pos_ff <= emit_pos_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      size_ff <= SB'(size_prod);
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         label_ff <= LABEL_BITS'(req_pixel_label);
      end
      if (cmd.wrap) begin
         rem_ff  <= DVW'(emit_pos_ff);
         dvs_ff  <= DVW'(w_cl) << (RB - 1);
         q_ff    <= '0;
         dcnt_ff <= DCB'(RB);
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_nx;
         dvs_ff  <= dvs_ff >> 1;
         q_ff    <= q_nx;
         dcnt_ff <= dcnt_ff - DCB'(1);
      end
      if (cmd.read_center) begin
         probe_ff <= emit_pos_ff;
      end
      if (cmd.center) begin
         center_ff <= rd_data_ff;
         k_ff      <= 8'd1;
         result_ff <= '0;
      end
      if (cmd.probe) begin
         probe_ff <= probe_next;
         if (probe_out) begin
            result_ff <= center_ff;
         end
      end
      if (cmd.compare) begin
         if (rd_data_ff != center_ff) begin
            result_ff <= center_ff;
         end else begin
            k_ff <= k_ff + 8'd1;
         end
      end
   end

   // status back to the controller
   always_comb begin
      status.is_emit      = (op_ff == dlb_pkg::OP_EMIT);
      status.pos_in_range = emit_in_range;
      status.div_last     = (dcnt_ff == DCB'(1));
      status.center_zero  = (rd_data_ff == '0) || (cfg.thickness == '0);
      status.probe_out    = probe_out;
      status.probe_diff   = (rd_data_ff != center_ff);
      status.probe_last   = (k_ff == cfg.thickness);
   end

   assign result_label = dlb_pkg::PIXEL_BITS'(result_ff);
   assign frame_end    = emit_last;

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench of directional_label_boundary: directed and random frames
module tb_top;

   localparam int unsigned MAX_DIM         = 256;
   localparam int unsigned RANDOM_ITEMS    = 500;
   localparam int unsigned DRAIN_CYCLES    = 16;
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned MISMATCH_REPORT = 10;

   typedef struct {
      logic [dlb_pkg::PIXEL_BITS-1:0] label;
      logic                           frame_end;
   } boundary_result_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic                               req_opcode;
   logic [dlb_pkg::PIXEL_BITS-1:0]     req_pixel_label;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [dlb_pkg::PIXEL_BITS-1:0]     rsp_boundary_label;
   logic                               rsp_frame_end;
   logic                               csr_write;
   logic [dlb_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [dlb_pkg::CSR_DATA_BITS-1:0]  csr_data;

   // predictor state: frame store copy, positions and registers
   logic [dlb_pkg::PIXEL_BITS-1:0] label_store [0:MAX_DIM*MAX_DIM-1];
   bit                             pixel_written [0:MAX_DIM*MAX_DIM-1];
   int unsigned                    load_pos;
   int unsigned                    emit_pos;
   logic [8:0]                     cfg_width;
   logic [8:0]                     cfg_height;
   dlb_pkg::side_type              cfg_side;
   logic [7:0]                     cfg_thickness;

   boundary_result_type            expected_boundaries [$];
   boundary_result_type            oldest_boundary;
   logic [dlb_pkg::PIXEL_BITS-1:0] palette [0:3];
   logic [dlb_pkg::PIXEL_BITS-1:0] last_label;
   int unsigned                    burst_left;
   int unsigned                    stall_run;
   int unsigned                    quiet_cycles;
   int unsigned                    mismatch_count;
   int unsigned                    results_checked;
   int unsigned                    loads_sent;
   int unsigned                    emits_sent;
   int unsigned                    settings_used;

   directional_label_boundary #(
      .MAX_WIDTH(MAX_DIM),
      .MAX_HEIGHT(MAX_DIM),
      .LABEL_BITS(dlb_pkg::PIXEL_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_pixel_label(req_pixel_label),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_boundary_label(rsp_boundary_label),
      .rsp_frame_end(rsp_frame_end),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // size register as the block uses it: zero is one, above the maximum is the maximum
   function automatic int unsigned dim_of(input logic [8:0] value);
      if (value == 9'd0)
         return 1;
      if (value > MAX_DIM)
         return MAX_DIM;
      return 32'(value);
   endfunction

   function automatic int unsigned frame_size();
      return dim_of(cfg_width) * dim_of(cfg_height);
   endfunction

   // label kept when a probed neighbor differs or lies outside the frame;
   // reads_ok drops when any store entry read was never written
   function automatic logic [dlb_pkg::PIXEL_BITS-1:0] boundary_at(input int unsigned pos,
                                                                  output bit reads_ok);
      int unsigned w, h, row, col, npos, k;
      logic [dlb_pkg::PIXEL_BITS-1:0] center;
      w = dim_of(cfg_width);
      h = dim_of(cfg_height);
      row = pos / w;
      col = pos % w;
      center = label_store[pos];
      reads_ok = pixel_written[pos];
      if (center == '0)
         return '0;
      for (k = 1; k <= cfg_thickness; k++) begin
         case (cfg_side)
            dlb_pkg::SIDE_TOP: begin
               if (k > row)
                  return center;
               npos = pos - k * w;
            end
            dlb_pkg::SIDE_BOTTOM: begin
               if (row + k >= h)
                  return center;
               npos = pos + k * w;
            end
            dlb_pkg::SIDE_RIGHT: begin
               if (col + k >= w)
                  return center;
               npos = pos + k;
            end
            default: begin
               if (k > col)
                  return center;
               npos = pos - k;
            end
         endcase
         if (!pixel_written[npos])
            reads_ok = 1'b0;
         if (label_store[npos] != center)
            return center;
      end
      return '0;
   endfunction

   // an emit may go out only if every entry it reads holds a loaded label
   function automatic bit emit_allowed();
      int unsigned pos;
      bit ok;
      pos = (emit_pos >= frame_size()) ? 0 : emit_pos;
      void'(boundary_at(pos, ok));
      return ok;
   endfunction

   // labels in runs, copied from the row above, from a small palette, or rarely at random
   function automatic logic [dlb_pkg::PIXEL_BITS-1:0] pick_label();
      int unsigned r, pos, w;
      r = $urandom_range(0, 99);
      w = dim_of(cfg_width);
      pos = (load_pos >= frame_size()) ? 0 : load_pos;
      if (r < 35)
         return last_label;
      if (r < 60 && pos >= w && pixel_written[pos - w])
         return label_store[pos - w];
      if (r < 93)
         return palette[$urandom_range(0, 3)];
      return dlb_pkg::PIXEL_BITS'($urandom);
   endfunction

   // predictor update for one accepted transaction
   function automatic void predict_transaction(input logic op,
                                               input logic [dlb_pkg::PIXEL_BITS-1:0] label);
      int unsigned size;
      bit ok;
      boundary_result_type result;
      size = frame_size();
      if (load_pos >= size)
         load_pos = 0;
      if (emit_pos >= size)
         emit_pos = 0;
      if (op == dlb_pkg::OP_LOAD) begin
         label_store[load_pos] = label;
         pixel_written[load_pos] = 1'b1;
         last_label = label;
         load_pos = (load_pos + 1 >= size) ? 0 : load_pos + 1;
         loads_sent++;
      end else begin
         result.label = boundary_at(emit_pos, ok);
         result.frame_end = (emit_pos + 1 == size);
         expected_boundaries.push_back(result);
         emit_pos = (emit_pos + 1 >= size) ? 0 : emit_pos + 1;
         emits_sent++;
      end
   endfunction

   // one transaction on the request side, bursts with random gaps between them
   task automatic send_transaction(input logic op,
                                   input logic [dlb_pkg::PIXEL_BITS-1:0] label);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pixel_label <= label;
      do @(posedge clock); while (req_stall);
      predict_transaction(op, label);
   endtask

   // loads and emits mixed at a given emit share; an emit that would read
   // unloaded entries becomes a load
   task automatic drive_pixels(input int unsigned count, input int unsigned emit_pct);
      repeat (count) begin
         if ($urandom_range(1, 100) <= emit_pct && emit_allowed())
            send_transaction(dlb_pkg::OP_EMIT, dlb_pkg::PIXEL_BITS'($urandom));
         else
            send_transaction(dlb_pkg::OP_LOAD, pick_label());
      end
   endtask

   // stop sending, let every result arrive and the last load finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_boundaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dlb_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [dlb_pkg::CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic program_frame(input logic [8:0] width, input logic [8:0] height,
                                input dlb_pkg::side_type dir, input logic [7:0] thick);
      wait_idle();
      write_csr(dlb_pkg::REG_FRAME_WIDTH, width);
      write_csr(dlb_pkg::REG_FRAME_HEIGHT, height);
      write_csr(dlb_pkg::REG_SIDE, dlb_pkg::CSR_DATA_BITS'(dir));
      write_csr(dlb_pkg::REG_THICKNESS, dlb_pkg::CSR_DATA_BITS'(thick));
      csr_write <= 1'b0;
      cfg_width = width;
      cfg_height = height;
      cfg_side = dir;
      cfg_thickness = thick;
      settings_used++;
   endtask

   task automatic shuffle_palette();
      palette[0] = '0;
      palette[1] = dlb_pkg::PIXEL_BITS'($urandom_range(1, 15));
      palette[2] = dlb_pkg::PIXEL_BITS'($urandom);
      palette[3] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h8000;
   endtask

   // single pixel frames, zero thickness, every side and a mid-frame shrink
   task automatic test_small_frames();
      program_frame(9'd0, 9'd0, dlb_pkg::SIDE_LEFT, 8'd255);
      send_transaction(dlb_pkg::OP_LOAD, 16'hFFFF);
      send_transaction(dlb_pkg::OP_EMIT, 16'h0000);
      send_transaction(dlb_pkg::OP_LOAD, 16'h0000);
      send_transaction(dlb_pkg::OP_EMIT, 16'hFFFF);
      // zero thickness clears every pixel
      program_frame(9'd2, 9'd2, dlb_pkg::SIDE_TOP, 8'd0);
      send_transaction(dlb_pkg::OP_LOAD, 16'h0001);
      send_transaction(dlb_pkg::OP_LOAD, 16'h8000);
      send_transaction(dlb_pkg::OP_LOAD, 16'hFFFF);
      send_transaction(dlb_pkg::OP_LOAD, 16'h0001);
      drive_pixels(4, 100);
      // half a frame, then the frame shrinks and emit position restarts
      program_frame(9'd2, 9'd2, dlb_pkg::SIDE_BOTTOM, 8'd1);
      drive_pixels(2, 100);
      program_frame(9'd1, 9'd2, dlb_pkg::SIDE_RIGHT, 8'd2);
      drive_pixels(2, 100);
      program_frame(9'd2, 9'd2, dlb_pkg::SIDE_TOP, 8'd1);
      drive_pixels(4, 100);
   endtask

   // sizes above the maximum clamp, full-length probes along a row and a column
   task automatic test_size_extremes();
      shuffle_palette();
      program_frame(9'd511, 9'd1, dlb_pkg::SIDE_RIGHT, 8'd255);
      drive_pixels(frame_size(), 0);
      drive_pixels(frame_size(), 100);
      program_frame(9'd1, 9'd300, dlb_pkg::SIDE_TOP, 8'd255);
      drive_pixels(frame_size(), 0);
      drive_pixels(frame_size(), 100);
   endtask

   // random geometry, side and thickness; whole frames, overlapped frames and noise
   task automatic test_random_frames();
      int unsigned start_count, r, w, h, pixels;
      logic [7:0] thick;
      start_count = loads_sent + emits_sent;
      while (loads_sent + emits_sent - start_count < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
         end else if (r < 86) begin
            w = $urandom_range(0, 2);
            h = $urandom_range(0, 3);
         end else if (r < 95) begin
            w = $urandom_range(9, 24);
            h = $urandom_range(1, 4);
         end else if (r < 98) begin
            w = $urandom_range(257, 511);
            h = 1;
         end else begin
            w = 1;
            h = $urandom_range(200, 300);
         end
         r = $urandom_range(0, 99);
         if (r < 55)
            thick = 8'($urandom_range(0, 3));
         else if (r < 75)
            thick = 8'($urandom_range(4, 16));
         else if (r < 88)
            thick = 8'd255;
         else
            thick = 8'($urandom_range(0, 255));
         shuffle_palette();
         program_frame(9'(w), 9'(h), dlb_pkg::side_type'($urandom_range(0, 3)), thick);
         pixels = frame_size();
         case ($urandom_range(0, 3))
            0, 1: begin
               drive_pixels(pixels, 0);
               drive_pixels(pixels, 100);
            end
            2: begin
               // next frame loads while this one is emitted
               drive_pixels(pixels, 0);
               drive_pixels(2 * pixels, 50);
            end
            default: begin
               // partial frames over labels left by earlier frames
               drive_pixels(2 * pixels, 50);
            end
         endcase
      end
   endtask

   // receiver: alternating free runs and stall runs of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_run <= ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 30);
      end else begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 11);
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_boundaries.size() == 0) begin
            if (mismatch_count < MISMATCH_REPORT)
               $display("unexpected result: label %h frame_end %b",
                        rsp_boundary_label, rsp_frame_end);
            mismatch_count++;
         end else begin
            oldest_boundary = expected_boundaries.pop_front();
            if (rsp_boundary_label !== oldest_boundary.label ||
                rsp_frame_end !== oldest_boundary.frame_end) begin
               if (mismatch_count < MISMATCH_REPORT)
                  $display({"mismatch at result %0d: label %h expected %h, ",
                            "frame_end %b expected %b"},
                           results_checked, rsp_boundary_label, oldest_boundary.label,
                           rsp_frame_end, oldest_boundary.frame_end);
               mismatch_count++;
            end
         end
         results_checked++;
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= dlb_pkg::OP_LOAD;
      req_pixel_label <= '0;
      csr_write <= 1'b0;
      csr_index <= dlb_pkg::REG_FRAME_WIDTH;
      csr_data <= '0;
      cfg_width = dlb_pkg::FRAME_WIDTH_RESET;
      cfg_height = dlb_pkg::FRAME_HEIGHT_RESET;
      cfg_side = dlb_pkg::SIDE_TOP;
      cfg_thickness = dlb_pkg::THICKNESS_RESET;
      load_pos = 0;
      emit_pos = 0;
      last_label = '0;
      burst_left = 0;
      mismatch_count = 0;
      results_checked = 0;
      loads_sent = 0;
      emits_sent = 0;
      settings_used = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_small_frames();
      test_size_extremes();
      test_random_frames();

      wait_idle();
      mismatch_count += expected_boundaries.size();
      $display("covered %0d pixel loads and %0d emits under %0d register settings",
               loads_sent, emits_sent, settings_used);
      $display("checked %0d boundary results, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
